>>> src/sbt_pkg.sv
// shared types and constants of the software breakpoint table
// depends on nothing; every other file of the block imports it
package sbt_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int ACTION_W  = 3;
  localparam int ADDR_W    = 64;
  localparam int STATUS_W  = 2;
  localparam int PSLOT_W   = 4;
  localparam int QDEPTH    = 2;

  // input action codes
  localparam logic [ACTION_W-1:0] ACT_SET     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ACT_ALL = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DEA_ALL = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REM_ALL = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_QUERY   = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STS_ALREADY  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STS_NO_SUCH  = 2'd3;

  // patch kinds
  localparam logic KIND_INSTALL = 1'b0;
  localparam logic KIND_RESTORE = 1'b1;

  typedef enum logic [2:0] {
    CMD_SET,
    CMD_REMOVE,
    CMD_ACT_ALL,
    CMD_DEA_ALL,
    CMD_REM_ALL,
    CMD_QUERY,
    CMD_NOP
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] address;
  } cmd_item_t;

  typedef enum logic [1:0] {
    ST_FREE,
    ST_SET,
    ST_ACTIVE,
    ST_REMOVED
  } slot_st_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_FINAL
  } bstate_t;

endpackage

>>> src/sbt_if.sv
// valid/ready channel interfaces of the breakpoint table: commands in, results out
// depends on sbt_pkg for the field widths
interface sbt_in_if
  import sbt_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ADDR_W-1:0]   address;

  modport source (output valid, action, address, input ready);
  modport sink   (input valid, action, address, output ready);
endinterface

interface sbt_out_if
  import sbt_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                patch_valid;
  logic                patch_kind;
  logic [PSLOT_W-1:0]  patch_slot;
  logic [ADDR_W-1:0]   patch_address;
  logic                is_removed;
  logic                last;

  modport source (output valid, status, patch_valid, patch_kind, patch_slot,
                  patch_address, is_removed, last, input ready);
  modport sink   (input valid, status, patch_valid, patch_kind, patch_slot,
                  patch_address, is_removed, last, output ready);
endinterface

>>> src/sbt_front.sv
// front end: accepts command items, decodes the action and queues them
// depends on sbt_pkg and sbt_in_if
module sbt_front
  import sbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sbt_in_if.sink     in_if,
  output cmd_item_t  q_item,
  output logic       q_valid,
  input  logic       q_ready
);

  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  cmd_item_t          q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  cmd_item_t          dec_item;
  logic               push, pop;

  always_comb begin
    dec_item.address = in_if.address;
    unique case (in_if.action)
      ACT_SET:     dec_item.cmd = CMD_SET;
      ACT_REMOVE:  dec_item.cmd = CMD_REMOVE;
      ACT_ACT_ALL: dec_item.cmd = CMD_ACT_ALL;
      ACT_DEA_ALL: dec_item.cmd = CMD_DEA_ALL;
      ACT_REM_ALL: dec_item.cmd = CMD_REM_ALL;
      ACT_QUERY:   dec_item.cmd = CMD_QUERY;
      default:     dec_item.cmd = CMD_NOP;
    endcase
  end

  assign in_if.ready = (cnt_r != CNT_W'(QDEPTH));
  assign q_valid     = (cnt_r != '0);
  assign q_item      = q_mem_r[rd_ptr_r];
  assign push        = in_if.valid && in_if.ready;
  assign pop         = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec_item;
    end
  end

endmodule

>>> src/sbt_back.sv
// back end: walks the slot table one slot a cycle unless the result output
// stalls, emits patch requests and status; depends on sbt_pkg and sbt_out_if;
// holds the slot states, the address memory and the output register
module sbt_back
  import sbt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_item_t  q_item,
  input  logic       q_valid,
  output logic       q_ready,
  sbt_out_if.source  out_if
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // slot storage
  slot_st_t           slot_st_r [SLOTS];
  logic [ADDR_W-1:0]  addr_mem [SLOTS];
  logic [ADDR_W-1:0]  mem_q_r;

  // sequencer
  bstate_t            state_r, state_nxt;
  cmd_item_t          cmd_r, cmd_nxt;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic               issued_all_r, issued_all_nxt;
  logic               eval_v_r, eval_v_nxt;
  logic [IDX_W-1:0]   eval_idx_r, eval_idx_nxt;

  // scan results: hit_a = set match, remove done or removed match
  logic               hit_a_r, hit_a_nxt;
  logic               hit_b_r, hit_b_nxt;
  logic [IDX_W-1:0]   idx_b_r, idx_b_nxt;
  logic               hit_c_r, hit_c_nxt;
  logic [IDX_W-1:0]   idx_c_r, idx_c_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_pv_r, out_kind_r, out_rem_r, out_last_r;
  logic [PSLOT_W-1:0]  out_slot_r;
  logic [ADDR_W-1:0]   out_addr_r;

  logic                out_free;
  logic                res_v;
  logic [STATUS_W-1:0] res_status;
  logic                res_pv, res_kind, res_rem, res_last;
  logic [PSLOT_W-1:0]  res_slot;
  logic [ADDR_W-1:0]   res_addr;

  logic               rd_en;
  logic               st_we;
  logic [IDX_W-1:0]   st_widx;
  slot_st_t           st_wdata;
  logic               mem_we;
  logic [IDX_W-1:0]   pick_idx;

  slot_st_t           cur;
  logic               match;
  logic               need_out, slot_upd, set_a, set_b, set_c;
  logic               out_kind_c;
  slot_st_t           slot_new;
  logic               eval_go, advance, slot_fire;

  assign out_free = !out_valid_r || out_if.ready;
  assign cur      = slot_st_r[eval_idx_r];
  assign match    = (mem_q_r == cmd_r.address);
  assign pick_idx = hit_b_r ? idx_b_r : idx_c_r;

  // what the slot under evaluation does for the current command
  always_comb begin
    need_out   = 1'b0;
    slot_upd   = 1'b0;
    slot_new   = cur;
    out_kind_c = KIND_RESTORE;
    set_a      = 1'b0;
    set_b      = 1'b0;
    set_c      = 1'b0;
    unique case (cmd_r.cmd)
      CMD_SET: begin
        set_a = (cur == ST_SET) && match;
        set_b = (cur == ST_REMOVED) && match && !hit_b_r;
        set_c = (cur == ST_FREE) && !hit_c_r;
      end
      CMD_REMOVE: begin
        if (!hit_a_r && match && (cur == ST_SET || cur == ST_ACTIVE)) begin
          set_a    = 1'b1;
          slot_upd = 1'b1;
          slot_new = ST_REMOVED;
          need_out = (cur == ST_ACTIVE);
        end
      end
      CMD_ACT_ALL: begin
        if (cur == ST_SET) begin
          need_out   = 1'b1;
          out_kind_c = KIND_INSTALL;
          slot_upd   = 1'b1;
          slot_new   = ST_ACTIVE;
        end
      end
      CMD_DEA_ALL: begin
        if (cur == ST_ACTIVE) begin
          need_out = 1'b1;
          slot_upd = 1'b1;
          slot_new = ST_SET;
        end
      end
      CMD_REM_ALL: begin
        need_out = (cur == ST_ACTIVE);
        slot_upd = 1'b1;
        slot_new = ST_FREE;
      end
      CMD_QUERY: begin
        set_a = (cur == ST_REMOVED) && match;
      end
      default: begin
      end
    endcase
  end

  assign eval_go   = !need_out || out_free;
  assign advance   = !eval_v_r || eval_go;
  assign slot_fire = (state_r == B_SCAN) && eval_v_r && eval_go;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    scan_idx_nxt   = scan_idx_r;
    issued_all_nxt = issued_all_r;
    eval_v_nxt     = eval_v_r;
    eval_idx_nxt   = eval_idx_r;
    hit_a_nxt      = hit_a_r;
    hit_b_nxt      = hit_b_r;
    idx_b_nxt      = idx_b_r;
    hit_c_nxt      = hit_c_r;
    idx_c_nxt      = idx_c_r;
    q_ready        = 1'b0;
    rd_en          = 1'b0;
    st_we          = 1'b0;
    st_widx        = eval_idx_r;
    st_wdata       = slot_new;
    mem_we         = 1'b0;
    res_v          = 1'b0;
    res_status     = STS_OK;
    res_pv         = 1'b0;
    res_kind       = 1'b0;
    res_slot       = '0;
    res_addr       = '0;
    res_rem        = 1'b0;
    res_last       = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cmd_nxt        = q_item;
          scan_idx_nxt   = '0;
          issued_all_nxt = 1'b0;
          eval_v_nxt     = 1'b0;
          hit_a_nxt      = 1'b0;
          hit_b_nxt      = 1'b0;
          hit_c_nxt      = 1'b0;
          state_nxt      = B_SCAN;
        end
      end
      B_SCAN: begin
        if (slot_fire) begin
          if (set_a) begin
            hit_a_nxt = 1'b1;
          end
          if (set_b) begin
            hit_b_nxt = 1'b1;
            idx_b_nxt = eval_idx_r;
          end
          if (set_c) begin
            hit_c_nxt = 1'b1;
            idx_c_nxt = eval_idx_r;
          end
          st_we = slot_upd;
          if (need_out) begin
            res_v    = 1'b1;
            res_pv   = 1'b1;
            res_kind = out_kind_c;
            res_slot = PSLOT_W'(eval_idx_r);
            res_addr = mem_q_r;
          end
          if (eval_idx_r == LAST_IDX) begin
            state_nxt = B_FINAL;
          end
        end
        // address read for the next slot overlaps evaluation of this one
        if (advance) begin
          if (!issued_all_r) begin
            rd_en        = 1'b1;
            eval_v_nxt   = 1'b1;
            eval_idx_nxt = scan_idx_r;
            if (scan_idx_r == LAST_IDX) begin
              issued_all_nxt = 1'b1;
            end else begin
              scan_idx_nxt = scan_idx_r + IDX_W'(1);
            end
          end else begin
            eval_v_nxt = 1'b0;
          end
        end
      end
      B_FINAL: begin
        if (out_free) begin
          res_v     = 1'b1;
          res_last  = 1'b1;
          state_nxt = B_IDLE;
          unique case (cmd_r.cmd)
            CMD_SET: begin
              if (hit_a_r) begin
                res_status = STS_ALREADY;
              end else if (hit_b_r || hit_c_r) begin
                st_we    = 1'b1;
                st_widx  = pick_idx;
                st_wdata = ST_SET;
                mem_we   = 1'b1;
              end else begin
                res_status = STS_FULL;
              end
            end
            CMD_REMOVE: res_status = hit_a_r ? STS_OK : STS_NO_SUCH;
            CMD_QUERY:  res_rem = hit_a_r;
            default: begin
            end
          endcase
        end
      end
      default: state_nxt = B_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (res_v) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      eval_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      eval_v_r    <= eval_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    scan_idx_r   <= scan_idx_nxt;
    issued_all_r <= issued_all_nxt;
    eval_idx_r   <= eval_idx_nxt;
    hit_a_r      <= hit_a_nxt;
    hit_b_r      <= hit_b_nxt;
    idx_b_r      <= idx_b_nxt;
    hit_c_r      <= hit_c_nxt;
    idx_c_r      <= idx_c_nxt;
    if (res_v) begin
      out_status_r <= res_status;
      out_pv_r     <= res_pv;
      out_kind_r   <= res_kind;
      out_slot_r   <= res_slot;
      out_addr_r   <= res_addr;
      out_rem_r    <= res_rem;
      out_last_r   <= res_last;
    end
  end

  // slot states live in flops so reset frees the whole table at once
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (!rst_n) begin
        slot_st_r[i] <= ST_FREE;
      end else if (st_we && st_widx == IDX_W'(i)) begin
        slot_st_r[i] <= st_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      addr_mem[pick_idx] <= cmd_r.address;
    end
    if (rd_en) begin
      mem_q_r <= addr_mem[scan_idx_r];
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_status_r;
  assign out_if.patch_valid   = out_pv_r;
  assign out_if.patch_kind    = out_kind_r;
  assign out_if.patch_slot    = out_slot_r;
  assign out_if.patch_address = out_addr_r;
  assign out_if.is_removed    = out_rem_r;
  assign out_if.last          = out_last_r;

endmodule

>>> src/sw_breakpoint_table.sv
// Software breakpoint table, top level: front end with command queue and the
// slot-walking back end. Depends on sbt_pkg, sbt_if, sbt_front and sbt_back.
//
// Every command walks all SLOTS slots, one slot per cycle through the single
// read port of the address memory, unless the result channel stalls, and the
// back end takes no new command until it has given the final status. Set,
// remove and query give one result; remove gives a restore request first when
// the breakpoint was in memory; the bulk commands give one install or restore
// request per affected slot, at most one per cycle, then the final status with
// last set. A two-entry queue in front takes new commands while the back end
// works. Slot states reset to free at once; there is no clearing pass.
module sw_breakpoint_table
  import sbt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  sbt_in_if.sink     in_if,
  sbt_out_if.source  out_if
);

  cmd_item_t q_item;
  logic      q_valid;
  logic      q_ready;

  sbt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  sbt_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .out_if  (out_if)
  );

endmodule
